/* rtl/core/tkssl_pkg.sv */
// Shared types and constants for the strongest-signal list core.
// No dependencies; imported by every module of the block.
`default_nettype none

package tkssl_pkg;

   localparam int LIST_DEPTH = 8;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W     = 48;
   localparam int RSSI_W     = 8;

   localparam logic signed [RSSI_W-1:0] EMPTY_STRENGTH = -8'sd127;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_OFFER  = 2'd1,
      ACT_READ   = 2'd2,
      ACT_IGNORE = 2'd3
   } action_type;

   // broadcast to every cell
   typedef struct packed {
      logic                     clear;
      logic                     take;
      logic signed [RSSI_W-1:0] strength;
      logic [ADDR_W-1:0]        address;
   } tkssl_cmd_type;

   // handed from a cell to its right-hand neighbour
   typedef struct packed {
      logic                     ge;
      logic signed [RSSI_W-1:0] strength;
      logic [ADDR_W-1:0]        address;
   } tkssl_link_type;

endpackage

`default_nettype wire

/* rtl/core/tkssl_cell.sv */
// One list slot: holds a strength and an address, compares against the offer.
// Depends on tkssl_pkg.
`default_nettype none

module tkssl_cell
   import tkssl_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire tkssl_cmd_type  cmd,
   input  wire logic           occupied,
   input  wire tkssl_link_type left_link,
   output      tkssl_link_type right_link,
   output      logic           ins_here
);

   logic signed [RSSI_W-1:0] strength_ff, strength_in;
   logic [ADDR_W-1:0]        address_ff, address_in;
   logic                     ge;
   logic                     load;

   // entry at or above the offer stays put
   assign ge       = occupied && (strength_ff >= cmd.strength);
   assign load     = cmd.take && !ge;
   assign ins_here = load && left_link.ge;

   always_comb begin
      strength_in = strength_ff;
      address_in  = address_ff;
      if (cmd.clear) begin
         strength_in = EMPTY_STRENGTH;
      end else if (load) begin
         if (left_link.ge) begin
            strength_in = cmd.strength;
            address_in  = cmd.address;
         end else begin
            strength_in = left_link.strength;
            address_in  = left_link.address;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= EMPTY_STRENGTH;
      end else begin
         strength_ff <= strength_in;
      end
   end

   always_ff @(posedge clock) begin
      address_ff <= address_in;
   end

   assign right_link = '{ge: ge, strength: strength_ff, address: address_ff};

endmodule

`default_nettype wire

/* rtl/core/top_k_strongest_signal_list_core.sv */
// Top level of the strongest-signal list: row of tkssl_cell slots plus count
// and response registers. Depends on tkssl_pkg and tkssl_cell.
//
// Keeps the LIST_DEPTH strongest qualifying advertisements, strongest first.
// A request is taken on any clock edge with start high; busy is never raised,
// so one request per cycle is sustained. Its response is registered and
// appears in the next cycle on the rsp_ ports with rsp_valid high for that single cycle;
// the receiver cannot stall it and must capture it then. Every slot of the
// cell row compares itself with the offer in parallel and
// either holds, takes the offer, or takes its left neighbour's entry, so an
// insertion completes in one compare-and-shift step.
`default_nettype none

module top_k_strongest_signal_list_core
   import tkssl_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire logic [1:0]               req_action,
   input  wire logic                     req_name_matches,
   input  wire logic                     req_has_service,
   input  wire logic [ADDR_W-1:0]        req_device_address,
   input  wire logic signed [RSSI_W-1:0] req_signal_strength,
   input  wire logic [2:0]               req_read_index,
   output      logic                     rsp_valid,
   output      logic                     rsp_accepted,
   output      logic [2:0]               rsp_placed_at,
   output      logic [3:0]               rsp_entry_count,
   output      logic                     rsp_read_valid,
   output      logic [ADDR_W-1:0]        rsp_read_address,
   output      logic signed [RSSI_W-1:0] rsp_read_strength
);

   tkssl_cmd_type  cmd;
   tkssl_link_type link [LIST_DEPTH+1];
   tkssl_link_type slot_view [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] ins_vec;
   logic [LIST_DEPTH-1:0] occ_vec;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             go;
   logic             offer_ok;
   logic             full;
   logic             take;
   action_type       act;

   logic             rsp_valid_ff;
   logic             accepted_ff, accepted_in;
   logic [2:0]       placed_ff, placed_in;
   logic [3:0]       entry_ff;
   logic             rvalid_ff, rvalid_in;
   logic [ADDR_W-1:0]        raddr_ff, raddr_in;
   logic signed [RSSI_W-1:0] rstr_ff, rstr_in;
   logic [IDX_W-1:0] ridx;
   logic [IDX_W-1:0] pos;

   assign busy     = 1'b0;
   assign go       = start && !busy;
   assign act      = action_type'(req_action);
   assign offer_ok = go && (act == ACT_OFFER) && (req_name_matches || req_has_service);
   assign full     = (count_ff == CNT_W'(LIST_DEPTH));
   // full list: drop unless stronger than the last entry
   assign take     = offer_ok && (!full || !link[LIST_DEPTH].ge);

   assign cmd = '{clear:    go && (act == ACT_CLEAR),
                  take:     take,
                  strength: req_signal_strength,
                  address:  req_device_address};

   // left edge acts as an always-stronger neighbour
   assign link[0] = '{ge: 1'b1, strength: '0, address: '0};

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      assign occ_vec[g] = (CNT_W'(g) < count_ff);
      // slot g's own contents, for reads
      assign slot_view[g] = link[g+1];
      tkssl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .occupied   (occ_vec[g]),
         .left_link  (link[g]),
         .right_link (link[g+1]),
         .ins_here   (ins_vec[g])
      );
   end

   // one-hot insertion point to index
   always_comb begin
      pos = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (ins_vec[i]) begin
            pos = pos | IDX_W'(i);
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (take && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign ridx = req_read_index[IDX_W-1:0];

   always_comb begin
      accepted_in = take;
      placed_in   = take ? 3'(pos) : 3'd0;
      rvalid_in   = 1'b0;
      raddr_in    = '0;
      rstr_in     = '0;
      case (act)
         ACT_READ: begin
            if (CNT_W'(req_read_index) < count_ff) begin
               rvalid_in = 1'b1;
               raddr_in  = slot_view[ridx].address;
               rstr_in   = slot_view[ridx].strength;
            end
         end
         default: begin
            rvalid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= go;
      end
   end

   always_ff @(posedge clock) begin
      accepted_ff <= accepted_in;
      placed_ff   <= placed_in;
      entry_ff    <= 4'(count_in);
      rvalid_ff   <= rvalid_in;
      raddr_ff    <= raddr_in;
      rstr_ff     <= rstr_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = accepted_ff;
   assign rsp_placed_at   = placed_ff;
   assign rsp_entry_count = entry_ff;
   assign rsp_read_valid  = rvalid_ff;
   assign rsp_read_address  = raddr_ff;
   assign rsp_read_strength = rstr_ff;

endmodule

`default_nettype wire

/* rtl/core/tkssl_checker.sv */
// Port-level checker for the strongest-signal list core, bound to the top.
// Depends on tkssl_pkg.
`default_nettype none

module tkssl_checker
   import tkssl_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     start,
   input wire logic                     busy,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_accepted,
   input wire logic [2:0]               rsp_placed_at,
   input wire logic [3:0]               rsp_entry_count,
   input wire logic                     rsp_read_valid,
   input wire logic [ADDR_W-1:0]        rsp_read_address,
   input wire logic signed [RSSI_W-1:0] rsp_read_strength
);

   // every request gets exactly one response, in the following cycle
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid) else $error("missing response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid) else $error("unrequested response");

   a_place_in_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> ({1'b0, rsp_placed_at} < rsp_entry_count))
      else $error("placement beyond entry count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= 4'(LIST_DEPTH)))
      else $error("entry count above depth");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_read_valid) |-> (rsp_read_address == '0 && rsp_read_strength == '0))
      else $error("read data without valid read");

endmodule

bind top_k_strongest_signal_list_core tkssl_checker u_tkssl_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_accepted      (rsp_accepted),
   .rsp_placed_at     (rsp_placed_at),
   .rsp_entry_count   (rsp_entry_count),
   .rsp_read_valid    (rsp_read_valid),
   .rsp_read_address  (rsp_read_address),
   .rsp_read_strength (rsp_read_strength)
);

`default_nettype wire

/* bench/top_k_strongest_signal_list_core_tb.sv */
// Self-checking bench for the strongest-signal list core: queued request driver,
// response monitor and an in-bench ranking predictor of the list contents.
// Depends on tkssl_pkg and top_k_strongest_signal_list_core.
`default_nettype none

module top_k_strongest_signal_list_core_tb;
   import tkssl_pkg::*;

   // one request as queued for the driver; gap_pct is the chance per cycle
   // that the driver sits idle before launching it
   typedef struct {
      action_type               action;
      logic                     name_matches;
      logic                     has_service;
      logic [ADDR_W-1:0]        address;
      logic signed [RSSI_W-1:0] strength;
      logic [2:0]               read_index;
      int unsigned              gap_pct;
   } advert_req_type;

   // what the list ought to answer for one request
   typedef struct {
      logic                     accepted;
      logic [2:0]               placed_at;
      logic [3:0]               entry_count;
      logic                     read_valid;
      logic [ADDR_W-1:0]        read_address;
      logic signed [RSSI_W-1:0] read_strength;
   } list_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic [1:0]               req_action = '0;
   logic                     req_name_matches = 1'b0;
   logic                     req_has_service = 1'b0;
   logic [ADDR_W-1:0]        req_device_address = '0;
   logic signed [RSSI_W-1:0] req_signal_strength = '0;
   logic [2:0]               req_read_index = '0;

   wire logic                     busy;
   wire logic                     rsp_valid;
   wire logic                     rsp_accepted;
   wire logic [2:0]               rsp_placed_at;
   wire logic [3:0]               rsp_entry_count;
   wire logic                     rsp_read_valid;
   wire logic [ADDR_W-1:0]        rsp_read_address;
   wire logic signed [RSSI_W-1:0] rsp_read_strength;

   top_k_strongest_signal_list_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_name_matches    (req_name_matches),
      .req_has_service     (req_has_service),
      .req_device_address  (req_device_address),
      .req_signal_strength (req_signal_strength),
      .req_read_index      (req_read_index),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_placed_at       (rsp_placed_at),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_read_valid      (rsp_read_valid),
      .rsp_read_address    (rsp_read_address),
      .rsp_read_strength   (rsp_read_strength)
   );

   always #1 clock = ~clock;

   advert_req_type adverts_to_send[$];
   list_rsp_type   outcomes_due[$];
   advert_req_type in_flight;          // request currently on the req_ ports
   int unsigned mismatches = 0;

   // predictor's own copy of the list
   logic signed [RSSI_W-1:0] rank_strength [LIST_DEPTH];
   logic [ADDR_W-1:0]        rank_address  [LIST_DEPTH];
   logic [3:0]               rank_count;

   task automatic empty_ranking();
      int i;
      rank_count = '0;
      for (i = 0; i < LIST_DEPTH; i++) rank_strength[i] = EMPTY_STRENGTH;
   endtask

   // Applies one request to the ranking and works out the response.
   // An entry climbs only past a strictly weaker one, so ties keep arrival order.
   task automatic rank_advert(input advert_req_type r, output list_rsp_type o);
      int pos;
      bit take;
      o.accepted      = 1'b0;
      o.placed_at     = '0;
      o.read_valid    = 1'b0;
      o.read_address  = '0;
      o.read_strength = '0;
      case (r.action)
         ACT_CLEAR: begin
            empty_ranking();
         end
         ACT_OFFER: begin
            if (r.name_matches || r.has_service) begin
               pos  = rank_count;
               take = 1'b1;
               if (rank_count < LIST_DEPTH) begin
                  rank_count = rank_count + 4'd1;
               end else if (r.strength <= rank_strength[LIST_DEPTH-1]) begin
                  take = 1'b0;     // full, and no stronger than the tail
               end else begin
                  pos = LIST_DEPTH - 1;
               end
               if (take) begin
                  while (pos > 0 && r.strength > rank_strength[pos-1]) begin
                     rank_strength[pos] = rank_strength[pos-1];
                     rank_address[pos]  = rank_address[pos-1];
                     pos--;
                  end
                  rank_strength[pos] = r.strength;
                  rank_address[pos]  = r.address;
                  o.accepted         = 1'b1;
                  o.placed_at        = pos[2:0];
               end
            end
         end
         ACT_READ: begin
            if (r.read_index < rank_count) begin
               o.read_valid    = 1'b1;
               o.read_address  = rank_address[r.read_index];
               o.read_strength = rank_strength[r.read_index];
            end
         end
         default: ;
      endcase
      o.entry_count = rank_count;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < 40)
         $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // Driver: a request is taken at an edge with start high and busy low.
   // Each port gets at most one nonblocking write per edge; while idle the
   // req_ ports carry noise so the core must ignore them.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      list_rsp_type due;
      bit launch;
      if (reset) begin
         start <= 1'b0;
         empty_ranking();
      end else begin
         if (start && !busy) begin
            rank_advert(in_flight, due);
            outcomes_due.push_back(due);
         end
         // a held request stays put until the core takes it
         if (!start || !busy) begin
            launch = 1'b0;
            if (adverts_to_send.size() != 0)
               launch = ($urandom_range(99) >= adverts_to_send[0].gap_pct);
            if (launch) begin
               in_flight = adverts_to_send.pop_front();
               req_action          <= in_flight.action;
               req_name_matches    <= in_flight.name_matches;
               req_has_service     <= in_flight.has_service;
               req_device_address  <= in_flight.address;
               req_signal_strength <= in_flight.strength;
               req_read_index      <= in_flight.read_index;
               start               <= 1'b1;
            end else begin
               req_action          <= 2'($urandom);
               req_name_matches    <= 1'($urandom);
               req_has_service     <= 1'($urandom);
               req_device_address  <= {16'($urandom), 32'($urandom)};
               req_signal_strength <= 8'($urandom);
               req_read_index      <= 3'($urandom);
               start               <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: rsp_valid marks a one-cycle response; it cannot be held off,
   // so every flagged cycle is checked against the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      list_rsp_type want;
      if (!reset && rsp_valid) begin
         if (outcomes_due.size() == 0) begin
            report_mismatch("response with no request due", 64'(rsp_entry_count), 64'hx);
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_accepted !== want.accepted)
               report_mismatch("accepted", 64'(rsp_accepted), 64'(want.accepted));
            if (rsp_placed_at !== want.placed_at)
               report_mismatch("placed_at", 64'(rsp_placed_at), 64'(want.placed_at));
            if (rsp_entry_count !== want.entry_count)
               report_mismatch("entry_count", 64'(rsp_entry_count), 64'(want.entry_count));
            if (rsp_read_valid !== want.read_valid)
               report_mismatch("read_valid", 64'(rsp_read_valid), 64'(want.read_valid));
            if (rsp_read_address !== want.read_address)
               report_mismatch("read_address", 64'(rsp_read_address),
                               64'(want.read_address));
            if (rsp_read_strength !== want.read_strength)
               report_mismatch("read_strength", 64'(unsigned'(rsp_read_strength)),
                               64'(unsigned'(want.read_strength)));
         end
      end
   end

   function automatic advert_req_type mk(input action_type act, input logic nm,
                                         input logic hs,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic signed [RSSI_W-1:0] rssi,
                                         input logic [2:0] idx, input int unsigned gap);
      advert_req_type r;
      r.action       = act;
      r.name_matches = nm;
      r.has_service  = hs;
      r.address      = addr;
      r.strength     = rssi;
      r.read_index   = idx;
      r.gap_pct      = gap;
      return r;
   endfunction

   // strengths drawn from a few shapes: anything, a tight band (ties),
   // the extremes, and at and just above the empty marker
   function automatic logic signed [RSSI_W-1:0] pick_strength();
      case ($urandom_range(3))
         0: return 8'($urandom);
         1: return 8'($urandom_range(200, 205));
         2: begin
            case ($urandom_range(3))
               0: return 8'sd127;
               1: return -8'sd128;
               2: return -8'sd127;
               default: return -8'sd126;
            endcase
         end
         default: return 8'($urandom_range(129, 136));
      endcase
   endfunction

   // Stimulus: directed requests first, then random phases of about a
   // hundred requests each, cycling through the sender idle rates.
   initial begin : stimulus
      int n, roll;
      int unsigned gap;
      int unsigned gap_by_phase[4];
      advert_req_type r;
      gap_by_phase = '{0, 58, 0, 9};

      // empty list: reads at both ends, non-qualifying offer, ignored action
      adverts_to_send.push_back(mk(ACT_READ,   0, 0, '0, '0, 3'd0, 0));
      adverts_to_send.push_back(mk(ACT_READ,   1, 1, '1, '1, 3'd7, 0));
      adverts_to_send.push_back(mk(ACT_OFFER,  0, 0, '1, 8'sd127, 3'd0, 0));
      adverts_to_send.push_back(mk(ACT_IGNORE, 1, 1, '1, 8'sd5, 3'd7, 0));
      // fill: name only, service only, both; extremes and ties
      adverts_to_send.push_back(mk(ACT_OFFER, 1, 0, '0, -8'sd128, 3'd0, 0));
      adverts_to_send.push_back(mk(ACT_OFFER, 0, 1, '1, 8'sd127, 3'd0, 0));
      adverts_to_send.push_back(mk(ACT_OFFER, 1, 1, 48'h0000_0000_0011, -8'sd127, 3'd0, 0));
      adverts_to_send.push_back(mk(ACT_OFFER, 1, 0, 48'h0000_0000_0022, 8'sd0, 3'd0, 0));
      adverts_to_send.push_back(mk(ACT_OFFER, 0, 1, 48'h0000_0000_0033, 8'sd0, 3'd0, 0));
      adverts_to_send.push_back(mk(ACT_OFFER, 1, 1, 48'h0000_0000_0044, 8'sd127, 3'd0, 0));
      adverts_to_send.push_back(mk(ACT_OFFER, 1, 0, 48'h0000_0000_0055, -8'sd60, 3'd0, 0));
      adverts_to_send.push_back(mk(ACT_OFFER, 0, 1, 48'h0000_0000_0066, -8'sd127, 3'd0, 0));
      // full: an offer equal to the tail is dropped, stronger ones take the tail
      adverts_to_send.push_back(mk(ACT_OFFER, 1, 1, 48'h0000_0000_0077, -8'sd128, 3'd0, 0));
      adverts_to_send.push_back(mk(ACT_OFFER, 1, 1, 48'h0000_0000_0088, -8'sd127, 3'd0, 0));
      adverts_to_send.push_back(mk(ACT_OFFER, 1, 1, 48'h0000_0000_0099, -8'sd126, 3'd0, 0));
      adverts_to_send.push_back(mk(ACT_OFFER, 0, 1, 48'h8000_0000_0000, 8'sd1, 3'd0, 0));
      for (n = 0; n < 8; n++)
         adverts_to_send.push_back(mk(ACT_READ, n[0], n[1], '1, '1, 3'(n), 0));
      adverts_to_send.push_back(mk(ACT_CLEAR, 1, 1, '1, 8'sd127, 3'd7, 0));
      adverts_to_send.push_back(mk(ACT_READ,  0, 0, '0, '0, 3'd0, 0));

      for (n = 0; n < 1300; n++) begin
         gap  = gap_by_phase[(n / 100) % 4];
         roll = $urandom_range(99);
         r = mk(ACT_READ, 1'($urandom), 1'($urandom), {16'($urandom), 32'($urandom)},
                pick_strength(), 3'($urandom), gap);
         if (roll < 3) begin
            r.action = ACT_CLEAR;
         end else if (roll < 6) begin
            r.action = ACT_IGNORE;
         end else if (roll < 55) begin
            r.action = ACT_OFFER;
            if (!r.name_matches && !r.has_service) r.has_service = 1'b1;
         end else if (roll < 62) begin
            r.action       = ACT_OFFER;     // fails the qualifying test
            r.name_matches = 1'b0;
            r.has_service  = 1'b0;
         end
         adverts_to_send.push_back(r);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // drain: every request taken and every response seen, then a short
      // pause for anything the core might still emit
      do @(negedge clock);
      while (adverts_to_send.size() != 0 || start || outcomes_due.size() != 0);
      repeat (5) @(negedge clock);
      if (outcomes_due.size() != 0)
         report_mismatch("responses missing", 64'd0, 64'(outcomes_due.size()));

      if (mismatches == 0) begin
         $display("top_k_strongest_signal_list_core regression: pass");
      end else begin
         $display("top_k_strongest_signal_list_core regression: fail");
      end
      $finish;
   end

   // hard stop, far beyond the slowest correct run
   initial begin : watchdog
      #400000;
      $display("top_k_strongest_signal_list_core regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
